[rtl/core/integer_text_parser_unit_assert.svh]
// Assertion helpers shared by the parser RTL.
// Both expect aclk and aresetn in scope.
`ifndef INTEGER_TEXT_PARSER_UNIT_ASSERT_SVH
`define INTEGER_TEXT_PARSER_UNIT_ASSERT_SVH

// Same-cycle implication.
`define ITP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define ITP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[rtl/core/itp_pkg.sv]
package itp_pkg;

    // frame length limit; bytes at or past it read as NUL
    localparam int MAX_LEN     = 255;
    localparam int POS_W       = $clog2(MAX_LEN + 1);

    localparam int CHAR_W      = 8;
    localparam int ACC_W       = 64;
    localparam int OFS_W       = 8;
    localparam int BASE_W      = 5;
    localparam int SHIFT_W     = 5;
    localparam int HEX_W       = 5;

    // hex value of a byte that is no hex digit
    localparam logic [HEX_W-1:0] HEX_NONE = HEX_W'(16);

    // config port
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_DATA_W  = 5;
    localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_BASE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] REG_ALLOW_MINUS  = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_SUFFIX  = CFG_IDX_W'(2);

    // classified-beat queue
    localparam int QUEUE_DEPTH = 4;
    localparam int Q_PTR_W     = $clog2(QUEUE_DEPTH);
    localparam int Q_CNT_W     = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        SUF_NONE,
        SUF_K,
        SUF_M,
        SUF_G
    } suf_t;

    typedef struct packed {
        logic [CHAR_W-1:0] character;
        logic              last;
    } in_item_t;

    typedef struct packed {
        logic [ACC_W-1:0] value;
        logic [OFS_W-1:0] end_offset;
    } out_item_t;

    typedef struct packed {
        logic [BASE_W-1:0] default_base;
        logic              allow_minus;
        logic              size_suffix;
    } cfg_t;

    // one character after classification
    typedef struct packed {
        logic [HEX_W-1:0] hex;
        logic             is_minus;
        logic             is_zero;
        logic             is_x;
        logic             is_i;
        logic             is_b;
        suf_t             suf;
        logic [POS_W-1:0] pos;
        logic [POS_W-1:0] end_pos;
        logic             last;
    } beat_t;

endpackage

[rtl/core/itp_front.sv]
module itp_front
    import itp_pkg::*;
(
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  in_item_t s_data,
    output logic     q_valid,
    input  logic     q_ready,
    output beat_t    q_data
);

    localparam logic [CHAR_W-1:0] CH_0       = 8'h30;
    localparam logic [CHAR_W-1:0] CH_9       = 8'h39;
    localparam logic [CHAR_W-1:0] CH_LOWER_A = 8'h61;
    localparam logic [CHAR_W-1:0] CH_LOWER_F = 8'h66;
    localparam logic [CHAR_W-1:0] CH_UPPER_A = 8'h41;
    localparam logic [CHAR_W-1:0] CH_UPPER_F = 8'h46;
    localparam logic [CHAR_W-1:0] CH_ALPHA   = 8'd10;
    localparam logic [CHAR_W-1:0] CH_MINUS   = 8'h2d;
    localparam logic [CHAR_W-1:0] CH_X       = 8'h78;
    localparam logic [CHAR_W-1:0] CH_I       = 8'h69;
    localparam logic [CHAR_W-1:0] CH_B       = 8'h42;
    localparam logic [CHAR_W-1:0] CH_G       = 8'h47;
    localparam logic [CHAR_W-1:0] CH_M       = 8'h4d;
    localparam logic [CHAR_W-1:0] CH_K       = 8'h4b;
    localparam logic [CHAR_W-1:0] CH_LOWER_K = 8'h6b;
    localparam logic [POS_W-1:0]  POS_LIMIT  = POS_W'(MAX_LEN);

    function automatic logic [HEX_W-1:0] hex_value(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] v;
        v = CHAR_W'(HEX_NONE);
        if (c inside {[CH_0:CH_9]}) begin
            v = c - CH_0;
        end else if (c inside {[CH_LOWER_A:CH_LOWER_F]}) begin
            v = c - CH_LOWER_A + CH_ALPHA;
        end else if (c inside {[CH_UPPER_A:CH_UPPER_F]}) begin
            v = c - CH_UPPER_A + CH_ALPHA;
        end
        return v[HEX_W-1:0];
    endfunction

    logic [POS_W-1:0]  pos_reg, pos_next;
    logic              in_range;
    logic [CHAR_W-1:0] c_eff;
    logic              push;

    assign s_ready  = q_ready;
    assign q_valid  = s_valid;
    assign push     = s_valid && s_ready;
    assign in_range = (pos_reg < POS_LIMIT);
    // past the length limit the byte reads as NUL
    assign c_eff    = in_range ? s_data.character : '0;

    always_comb begin
        q_data          = '0;
        q_data.hex      = hex_value(c_eff);
        q_data.is_minus = (c_eff == CH_MINUS);
        q_data.is_zero  = (c_eff == CH_0);
        q_data.is_x     = (c_eff == CH_X);
        q_data.is_i     = (c_eff == CH_I);
        q_data.is_b     = (c_eff == CH_B);
        case (c_eff)
            CH_G:             q_data.suf = SUF_G;
            CH_M:             q_data.suf = SUF_M;
            CH_K, CH_LOWER_K: q_data.suf = SUF_K;
            default:          q_data.suf = SUF_NONE;
        endcase
        q_data.pos      = pos_reg;
        q_data.end_pos  = in_range ? pos_reg + 1'b1 : pos_reg;
        q_data.last     = s_data.last;
    end

    always_comb begin
        pos_next = pos_reg;
        if (push) begin
            if (s_data.last) begin
                pos_next = '0;
            end else if (in_range) begin
                pos_next = pos_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg <= '0;
        end else begin
            pos_reg <= pos_next;
        end
    end

endmodule

[rtl/core/itp_queue.sv]
`include "integer_text_parser_unit_assert.svh"

module itp_queue
    import itp_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  in_valid,
    output logic  in_ready,
    input  beat_t in_data,
    output logic  out_valid,
    input  logic  out_ready,
    output beat_t out_data
);

    localparam logic [Q_PTR_W-1:0] PTR_LAST = Q_PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [Q_CNT_W-1:0] CNT_FULL = Q_CNT_W'(QUEUE_DEPTH);

    beat_t              mem_reg [QUEUE_DEPTH];
    logic [Q_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [Q_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [Q_CNT_W-1:0] count_reg, count_next;
    logic               push, pop;

    assign in_ready  = (count_reg != CNT_FULL);
    assign out_valid = (count_reg != '0);
    assign out_data  = mem_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= in_data;
        end
    end

    `ITP_ASSERT_NOW(a_cnt_bound, 1'b1, count_reg <= CNT_FULL, "queue count overflow")
    `ITP_ASSERT_NEXT(a_cnt_up, push && !pop, count_reg == $past(count_reg) + 1'b1, "count up")
    `ITP_ASSERT_NEXT(a_cnt_dn, pop && !push, count_reg == $past(count_reg) - 1'b1, "count dn")

endmodule

[rtl/core/itp_back.sv]
`include "integer_text_parser_unit_assert.svh"

module itp_back
    import itp_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  cfg_t      cfg,
    input  logic      q_valid,
    output logic      q_ready,
    input  beat_t     q_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    localparam logic [BASE_W-1:0]  BASE_OCT = BASE_W'(8);
    localparam logic [BASE_W-1:0]  BASE_DEC = BASE_W'(10);
    localparam logic [BASE_W-1:0]  BASE_HEX = BASE_W'(16);
    localparam logic [SHIFT_W-1:0] SHIFT_K  = SHIFT_W'(10);
    localparam logic [SHIFT_W-1:0] SHIFT_M  = SHIFT_W'(20);
    localparam logic [SHIFT_W-1:0] SHIFT_G  = SHIFT_W'(30);

    typedef enum logic [2:0] {
        PH_START,
        PH_FIRST,
        PH_ZERO,
        PH_X,
        PH_DIGITS,
        PH_SUF_I,
        PH_SUF_B,
        PH_DONE
    } phase_t;

    typedef struct packed {
        phase_t             phase;
        logic [BASE_W-1:0]  base;
        logic [ACC_W-1:0]   acc;
        logic               neg;
        logic [POS_W-1:0]   stop;
        logic [SHIFT_W-1:0] shift;
    } pstate_t;

    typedef struct packed {
        logic [ACC_W-1:0]   acc;
        logic               neg;
        logic [POS_W-1:0]   stop;
        logic [SHIFT_W-1:0] shift;
    } fin_t;

    function automatic logic [BASE_W-1:0] pick_base(input logic [BASE_W-1:0] dflt,
                                                    input logic [BASE_W-1:0] auto_base);
        return (dflt != '0) ? dflt : auto_base;
    endfunction

    // take a digit, or stop here and check for a size suffix
    function automatic pstate_t digit_or_stop(input pstate_t s, input beat_t b,
                                              input logic [POS_W-1:0] pos, input cfg_t c);
        pstate_t r;
        r = s;
        if (b.hex < HEX_NONE && b.hex < s.base) begin
            r.acc   = s.acc * ACC_W'(s.base) + ACC_W'(b.hex);
            r.phase = PH_DIGITS;
        end else begin
            r.stop  = pos;
            r.phase = PH_DONE;
            if (c.size_suffix) begin
                case (b.suf)
                    SUF_G: begin
                        r.shift = SHIFT_G;
                        r.phase = PH_SUF_I;
                    end
                    SUF_M: begin
                        r.shift = SHIFT_M;
                        r.phase = PH_SUF_I;
                    end
                    SUF_K: begin
                        r.shift = SHIFT_K;
                        r.phase = PH_SUF_I;
                    end
                    default: ;
                endcase
            end
        end
        return r;
    endfunction

    function automatic pstate_t feed(input pstate_t s, input beat_t b,
                                     input logic [POS_W-1:0] pos, input cfg_t c);
        pstate_t r;
        logic    first;
        r     = s;
        first = 1'b0;
        case (s.phase)
            PH_START: begin
                if (c.allow_minus && b.is_minus) begin
                    r.neg   = 1'b1;
                    r.phase = PH_FIRST;
                end else begin
                    first = 1'b1;
                end
            end
            PH_FIRST: first = 1'b1;
            PH_ZERO: begin
                if (b.is_x) begin
                    r.phase = PH_X;
                end else begin
                    r.base = pick_base(c.default_base, BASE_OCT);
                    r      = digit_or_stop(r, b, pos, c);
                end
            end
            PH_X: begin
                if (b.hex < HEX_NONE) begin
                    r.base = BASE_HEX;
                    r      = digit_or_stop(r, b, pos, c);
                end else begin
                    // lone 0x: stop at the x
                    r.base  = pick_base(c.default_base, BASE_OCT);
                    r.stop  = pos - 1'b1;
                    r.phase = PH_DONE;
                end
            end
            PH_DIGITS: r = digit_or_stop(r, b, pos, c);
            PH_SUF_I: begin
                if (b.is_i) begin
                    r.stop  = pos + 1'b1;
                    r.phase = PH_SUF_B;
                end else begin
                    r.phase = PH_DONE;
                end
            end
            PH_SUF_B: begin
                if (b.is_b) begin
                    r.stop = pos + 1'b1;
                end
                r.phase = PH_DONE;
            end
            default: r.phase = PH_DONE;
        endcase
        if (first) begin
            if (b.is_zero) begin
                r.acc   = '0;
                r.phase = PH_ZERO;
            end else begin
                r.base = pick_base(c.default_base, BASE_DEC);
                r      = digit_or_stop(r, b, pos, c);
            end
        end
        return r;
    endfunction

    pstate_t   st_reg, st_next, st_char, st_end;
    beat_t     nul_beat;
    fin_t      fin_reg, fin_next;
    logic      fin_valid_reg, fin_valid_next;
    out_item_t out_reg, out_next;
    logic      out_valid_reg, out_valid_next;
    logic      pop, out_load;
    logic [ACC_W-1:0] scaled;

    always_comb begin
        nul_beat     = '0;
        nul_beat.hex = HEX_NONE;
    end

    assign out_load = fin_valid_reg && (!out_valid_reg || m_ready);
    // a frame's final beat waits only while the finish slot is held
    assign q_ready  = !q_data.last || !fin_valid_reg || out_load;
    assign pop      = q_valid && q_ready;

    // the character, then the NUL that ends the frame
    assign st_char  = feed(st_reg, q_data, q_data.pos, cfg);
    assign st_end   = feed(st_char, nul_beat, q_data.end_pos, cfg);

    always_comb begin
        st_next        = st_reg;
        fin_next       = fin_reg;
        fin_valid_next = fin_valid_reg && !out_load;
        if (pop) begin
            if (q_data.last) begin
                st_next        = '0;
                fin_next.acc   = st_end.acc;
                fin_next.neg   = st_end.neg;
                fin_next.stop  = st_end.stop;
                fin_next.shift = st_end.shift;
                fin_valid_next = 1'b1;
            end else begin
                st_next = st_char;
            end
        end
    end

    assign scaled = fin_reg.acc << fin_reg.shift;

    always_comb begin
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !m_ready;
        if (out_load) begin
            out_next.value      = fin_reg.neg ? ('0 - scaled) : scaled;
            out_next.end_offset = OFS_W'(fin_reg.stop);
            out_valid_next      = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg        <= '0;
            fin_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            st_reg        <= st_next;
            fin_valid_reg <= fin_valid_next;
            out_valid_reg <= out_valid_next;
        end
        fin_reg <= fin_next;
        out_reg <= out_next;
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    `ITP_ASSERT_NEXT(a_fin_load, pop && q_data.last, fin_valid_reg, "finish slot not loaded")
    `ITP_ASSERT_NEXT(a_frame_clr, pop && q_data.last, st_reg.phase == PH_START, "frame not cleared")
    `ITP_ASSERT_NEXT(a_fin_hold, fin_valid_reg && !out_load, fin_valid_reg && $stable(fin_reg),
                     "finish slot lost")

endmodule

[rtl/core/integer_text_parser_unit.sv]
// Integer text parser: parses an integer, optionally negative, from the start of a text frame.
// s_ channel: one character per beat, s_data.last marks the frame's final beat.
// m_ channel: one result beat per frame (value mod 2^64 and end_offset).
// cfg_ channel: register writes (default_base, allow_minus, size_suffix), always
// ready; write only while no frame is in flight.
// Throughput: one character per cycle while the receiver takes results; the
// digit multiply-add in itp_back runs once per cycle.
// Result path: once accepted, the last character is held in a queue slot,
// then its result in the finish slot, which loads the scale/negate output
// register.
// Receiver stall: m_valid holds with its data; a finished frame waits in a
// second slot and the parser keeps taking characters of the next frame up to
// its final beat, which then waits at the queue head; once the queue fills,
// s_ready drops.
// Reset (aresetn low, synchronous): clears config registers to 0, parser state, queue
// and both result slots; no clearing pass is needed.
module integer_text_parser_unit
    import itp_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // character input
    input  logic                  s_valid,
    output logic                  s_ready,
    input  in_item_t              s_data,
    // result output
    output logic                  m_valid,
    input  logic                  m_ready,
    output out_item_t             m_data,
    // register writes
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    cfg_t  cfg_reg, cfg_next;
    logic  q_in_valid, q_in_ready;
    beat_t q_in_data;
    logic  q_out_valid, q_out_ready;
    beat_t q_out_data;

    // register file: takes a write beat every cycle
    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready) begin
            case (cfg_index)
                REG_DEFAULT_BASE: cfg_next.default_base = cfg_data[BASE_W-1:0];
                REG_ALLOW_MINUS:  cfg_next.allow_minus  = cfg_data[0];
                REG_SIZE_SUFFIX:  cfg_next.size_suffix  = cfg_data[0];
                default: ;  // unknown index: dropped
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    // front: position tracking and character classes
    itp_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_valid (q_in_valid),
        .q_ready (q_in_ready),
        .q_data  (q_in_data)
    );

    // short queue so front and back stall independently
    itp_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (q_in_valid),
        .in_ready  (q_in_ready),
        .in_data   (q_in_data),
        .out_valid (q_out_valid),
        .out_ready (q_out_ready),
        .out_data  (q_out_data)
    );

    // back: parse state machine, accumulator, scale/negate and result register
    itp_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .q_valid (q_out_valid),
        .q_ready (q_out_ready),
        .q_data  (q_out_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule
